>>> rtl/rps_pkg.sv
// rps_pkg: shared types, constants and helper functions of the radix partition scatter unit.
// Used by rps_core, radix_partition_scatter_unit and rps_checker.
package rps_pkg;

	localparam int INDEX_BITS = 20;
	localparam int BUCKETS    = 256;
	localparam int ADDR_W     = $clog2(BUCKETS);
	localparam int ENTRY_W    = INDEX_BITS + 1;
	localparam int BASE_W     = 20;
	localparam int SEL_W      = 4;
	localparam int SUM_W      = ((ENTRY_W > BASE_W) ? ENTRY_W : BASE_W) + 1;
	localparam int KEY_W      = 64;
	localparam int ROW_W      = 64;
	localparam int IN_DATA_W  = ((KEY_W + ROW_W + 7) / 8) * 8;
	localparam int OUT_FLD_W  = INDEX_BITS + KEY_W + ROW_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int CFG_W      = BASE_W;

	localparam logic [7:0]            DIGIT_MASK = 8'hff;
	localparam logic [INDEX_BITS-1:0] INDEX_MAX  = '1;
	localparam logic [ENTRY_W-1:0]    ENTRY_MAX  = '1;
	localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(BUCKETS - 1);

	// register indexes
	localparam logic CFG_KEY_BYTE_SELECT = 1'b0;
	localparam logic CFG_PARTITION_BASE  = 1'b1;

	typedef enum logic [1:0] {
		MODE_COUNT   = 2'd0,
		MODE_PREFIX  = 2'd1,
		MODE_SCATTER = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_PFX_START,
		ST_PFX,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic [INDEX_BITS-1:0] tgt_index;
		logic [KEY_W-1:0]      key;
		logic [ROW_W-1:0]      row_id;
		logic                  last;
		logic                  overflow;
	} res_t;

	// selected key byte; 0 acts as 1, 9..15 act as 8
	function automatic logic [ADDR_W-1:0] digit_of(input logic [KEY_W-1:0] key,
		input logic [SEL_W-1:0] sel);
		logic [2:0] idx;
		if (sel <= SEL_W'(1)) begin
			idx = 3'd7;
		end else if (sel >= SEL_W'(8)) begin
			idx = 3'd0;
		end else begin
			idx = 3'(SEL_W'(8) - sel);
		end
		return ADDR_W'(key[{idx, 3'b000} +: 8] & DIGIT_MASK);
	endfunction

	function automatic logic [ENTRY_W-1:0] sat_inc(input logic [ENTRY_W-1:0] e);
		return (e == ENTRY_MAX) ? e : e + ENTRY_W'(1);
	endfunction

	function automatic logic [ENTRY_W-1:0] sat_add(input logic [ENTRY_W-1:0] a,
		input logic [ENTRY_W-1:0] b);
		logic [ENTRY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ENTRY_W] ? ENTRY_MAX : s[ENTRY_W-1:0];
	endfunction

endpackage

>>> rtl/rps_ram.sv
// rps_ram: generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module rps_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/rps_core.sv
// rps_core: bucket table in RAM with valid bits, read-modify-write path with forwarding,
// and the sequencer for prefix walk and table clear. Depends on rps_pkg and rps_ram.
module rps_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rps_pkg::mode_t              in_mode,
	input  logic [rps_pkg::KEY_W-1:0]   in_key,
	input  logic [rps_pkg::ROW_W-1:0]   in_row_id,
	input  logic                        in_last,
	input  logic [rps_pkg::SEL_W-1:0]   key_byte_select,
	input  logic [rps_pkg::BASE_W-1:0]  partition_base,
	input  logic                        out_free,
	output rps_pkg::res_t               res
);
	import rps_pkg::*;

	state_t state_q, state_d;

	logic                valid_s1;
	mode_t               mode_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [ROW_W-1:0]    row_s1;
	logic                last_s1;
	logic [ADDR_W-1:0]   rd_addr_s1;
	logic                rd_valid_s1;

	logic [BUCKETS-1:0]  valid_q;
	logic                fwd_v_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	logic [ENTRY_W-1:0]  fwd_data_q;
	logic [ENTRY_W-1:0]  run_q;

	logic                s1_done, accept, acc_rmw, re, we, clear_all;
	logic [ADDR_W-1:0]   raddr;
	logic [ENTRY_W-1:0]  rdata, ent, wdata;
	logic [SUM_W-1:0]    tgt_sum;
	logic                ovf;

	rps_ram #(.DEPTH(BUCKETS), .WIDTH(ENTRY_W)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (rd_addr_s1),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// current entry value: last write wins, unwritten entries read as zero
	assign ent = (fwd_v_q && fwd_addr_q == rd_addr_s1) ? fwd_data_q :
		(rd_valid_s1 ? rdata : '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (accept && in_mode == MODE_PREFIX) begin
					state_d = ST_PFX_START;
				end else if (accept && in_mode == MODE_CLEAR) begin
					state_d = ST_CLEAR;
				end
			end
			ST_PFX_START: begin
				if (!valid_s1) begin
					state_d = ST_PFX;
				end
			end
			ST_PFX: begin
				if (rd_addr_s1 == LAST_ADDR) begin
					state_d = ST_RUN;
				end
			end
			ST_CLEAR: begin
				if (!valid_s1) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		s1_done   = valid_s1 && (mode_s1 != MODE_SCATTER || out_free);
		in_ready  = (state_q == ST_RUN) && (!valid_s1 || s1_done);
		accept    = in_valid && in_ready;
		acc_rmw   = accept && (in_mode == MODE_COUNT || in_mode == MODE_SCATTER);
		clear_all = 1'b0;
		re        = 1'b0;
		raddr     = digit_of(in_key, key_byte_select);
		we        = s1_done;
		wdata     = sat_inc(ent);
		case (state_q)
			ST_RUN: begin
				re = acc_rmw;
			end
			ST_PFX_START: begin
				re    = !valid_s1;
				raddr = '0;
			end
			ST_PFX: begin
				we    = 1'b1;
				wdata = run_q;
				re    = (rd_addr_s1 != LAST_ADDR);
				raddr = rd_addr_s1 + ADDR_W'(1);
			end
			ST_CLEAR: begin
				clear_all = !valid_s1;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	assign tgt_sum = SUM_W'(ent) + SUM_W'(partition_base);
	assign ovf     = tgt_sum > SUM_W'(INDEX_MAX);

	always_comb begin
		res.valid     = s1_done && mode_s1 == MODE_SCATTER;
		res.tgt_index = ovf ? INDEX_MAX : tgt_sum[INDEX_BITS-1:0];
		res.key       = key_s1;
		res.row_id    = row_s1;
		res.last      = last_s1;
		res.overflow  = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			valid_s1 <= 1'b0;
			valid_q  <= '0;
			fwd_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_rmw) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (clear_all) begin
				valid_q <= '0;
				fwd_v_q <= 1'b0;
			end else if (we) begin
				valid_q[rd_addr_s1] <= 1'b1;
				fwd_v_q             <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rmw) begin
			mode_s1 <= in_mode;
			key_s1  <= in_key;
			row_s1  <= in_row_id;
			last_s1 <= in_last;
		end
		if (re) begin
			rd_addr_s1  <= raddr;
			rd_valid_s1 <= valid_q[raddr];
		end
		if (we) begin
			fwd_addr_q <= rd_addr_s1;
			fwd_data_q <= wdata;
		end
		if (state_q == ST_PFX_START) begin
			run_q <= '0;
		end else if (state_q == ST_PFX) begin
			run_q <= sat_add(run_q, ent);
		end
	end

endmodule

>>> rtl/radix_partition_scatter_unit.sv
// radix_partition_scatter_unit: top level, configuration registers and output register.
// Depends on rps_pkg and rps_core.
//
// Usage: tuples enter on the s_axis channel, mode in tuser, key and row id in tdata,
// last_of_pass in tlast. Count and scatter beats look up the bucket named by the
// selected key byte in a 256-entry table held in a RAM; prefix beats turn the counts
// into running offsets, clear beats empty the table.
// Throughput: count and scatter take one beat per cycle unless a scatter waits for the
// output register; a RAM read is issued at accept and the entry is written back when the
// RAM stage completes; a forwarding register covers back-to-back hits on one bucket.
// A prefix beat walks the RAM one entry per cycle and holds s_axis_tready low until the
// walk ends; a clear beat drops all valid bits at once, holding tready low as it does.
// A scatter beat passes the RAM stage and then the output register on its way to m_axis,
// waiting in the RAM stage while the output register is full. Only scatter beats produce
// output; tlast echoes last_of_pass, tuser flags index overflow.
// A stalled m_axis holds its beat; one more scatter may wait in the RAM stage while
// further count beats are held back behind it.
// Reset: table reads as all zero, key_byte_select = 1, partition_base = 0, no output.
// The user writes configuration via cfg_we/cfg_index/cfg_wdata only while idle (not enforced).
module radix_partition_scatter_unit
	import rps_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_DATA_W-1:0]      s_axis_tdata,   // key, row_id
	input  logic [1:0]                s_axis_tuser,   // mode
	input  logic                      s_axis_tlast,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_DATA_W-1:0]     m_axis_tdata,   // tgt_index, out_key, out_row_id
	output logic                      m_axis_tuser,   // index_overflow
	output logic                      m_axis_tlast
);

	logic [SEL_W-1:0]      key_byte_select_q;
	logic [BASE_W-1:0]     partition_base_q;
	logic                  out_v_q;
	logic [INDEX_BITS-1:0] tgt_q;
	logic [KEY_W-1:0]      key_q;
	logic [ROW_W-1:0]      row_q;
	logic                  last_q;
	logic                  ovf_q;
	logic                  out_free;
	res_t                  res;

	assign out_free = !out_v_q || m_axis_tready;

	rps_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_mode         (mode_t'(s_axis_tuser)),
		.in_key          (s_axis_tdata[KEY_W-1:0]),
		.in_row_id       (s_axis_tdata[KEY_W+ROW_W-1:KEY_W]),
		.in_last         (s_axis_tlast),
		.key_byte_select (key_byte_select_q),
		.partition_base  (partition_base_q),
		.out_free        (out_free),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_byte_select_q <= SEL_W'(1);
			partition_base_q  <= '0;
			out_v_q           <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_KEY_BYTE_SELECT) begin
				key_byte_select_q <= cfg_wdata[SEL_W-1:0];
			end
			if (cfg_we && cfg_index == CFG_PARTITION_BASE) begin
				partition_base_q <= cfg_wdata[BASE_W-1:0];
			end
			if (res.valid) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			tgt_q  <= res.tgt_index;
			key_q  <= res.key;
			row_q  <= res.row_id;
			last_q <= res.last;
			ovf_q  <= res.overflow;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_DATA_W'({row_q, key_q, tgt_q});
	assign m_axis_tuser  = ovf_q;
	assign m_axis_tlast  = last_q;

endmodule

>>> rtl/rps_checker.sv
// rps_checker: port-level assertions for radix_partition_scatter_unit, bound to the top.
// Depends on rps_pkg.
module rps_checker
	import rps_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [1:0]            s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser
);

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[INDEX_BITS-1:0] == INDEX_MAX)
		else $error("overflow beat without saturated index");

	a_walk_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (s_axis_tuser == MODE_PREFIX || s_axis_tuser == MODE_CLEAR)
		|=> !s_axis_tready)
		else $error("input taken during table walk or clear");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_beat && s_axis_tuser == MODE_SCATTER, 2))
		else $error("output beat without a scatter beat two cycles earlier");

endmodule

bind radix_partition_scatter_unit rps_checker u_rps_checker (.*);
